[hdl/mcc_pkg.sv]
// shared types, constants and helpers for the minimum coin change block
`timescale 1ns / 1ps
`default_nettype none
package mcc_pkg;

  // field widths
  localparam int VAL_W  = 10;
  localparam int CNT_W  = 10;
  localparam int BEST_W = 11;
  localparam int IDX_W  = 2;

  // configuration register count and table markers
  localparam int REG_COUNT = 4;
  localparam int UNREACH_BIT = 10;
  localparam logic [BEST_W-1:0] BEST_INIT = 11'h7FF;
  localparam logic [CNT_W-1:0] CNT_MAX = 10'h3FF;

  // reset denominations, zero beyond the register list
  function automatic logic [VAL_W-1:0] coin_reset(input int i);
    logic [VAL_W-1:0] v;
    case (i)
      0: v = 10'd50;
      1: v = 10'd30;
      2: v = 10'd5;
      3: v = 10'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic fill;
    logic walk_rd;
    logic walk_upd;
    logic emit_next;
  } mcc_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic fill_skip;
    logic fill_end;
    logic walk_done;
    logic emit_last;
  } mcc_status_t;

endpackage
`default_nettype wire

[hdl/min_coin_change.sv]
// top level of the minimum coin change block
// one amount at a time: in_ready is high only while no transaction is in progress
// each transaction fills the count table up to the amount (unless zero or too big),
//   walks back along the coins used, then gives NUM_COINS result transactions
// the fill rate is set by the single read port of the count table: one coin per cycle
// reset (synchronous, rst high) returns to idle and loads denominations 50, 30, 5, 1
`timescale 1ns / 1ps
`default_nettype none
module min_coin_change #(
  parameter int MAX_AMOUNT = 1023,
  parameter int NUM_COINS  = 4
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           cfg_we,
  input  wire [mcc_pkg::IDX_W-1:0]      cfg_index,
  input  wire [mcc_pkg::VAL_W-1:0]      cfg_data,
  input  wire                           in_valid,
  output logic                          in_ready,
  input  wire [mcc_pkg::VAL_W-1:0]      amount,
  output logic                          out_valid,
  input  wire                           out_ready,
  output logic [mcc_pkg::VAL_W-1:0]     coin_value,
  output logic [mcc_pkg::CNT_W-1:0]     coin_count,
  output logic                          unreachable,
  output logic                          last
);
  import mcc_pkg::*;

  mcc_cmd_t    cmd;
  mcc_status_t st;

  // controller
  mcc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  // datapath
  mcc_datapath #(
    .MAX_AMOUNT (MAX_AMOUNT),
    .NUM_COINS  (NUM_COINS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .amount      (amount),
    .cmd         (cmd),
    .st          (st),
    .coin_value  (coin_value),
    .coin_count  (coin_count),
    .unreachable (unreachable),
    .last        (last)
  );

endmodule
`default_nettype wire

[hdl/mcc_ctrl.sv]
// controller state machine for the minimum coin change block
`timescale 1ns / 1ps
`default_nettype none
module mcc_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire                  out_ready,
  input  mcc_pkg::mcc_status_t st,
  output mcc_pkg::mcc_cmd_t    cmd
);
  import mcc_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_FILL     = 3'd1;
  localparam logic [2:0] S_WALK_RD  = 3'd2;
  localparam logic [2:0] S_WALK_UPD = 3'd3;
  localparam logic [2:0] S_EMIT     = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  // handshake outputs come straight from the state register
  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_EMIT);

  // commands
  always_comb begin
    cmd           = '0;
    cmd.load      = in_valid && in_ready;
    cmd.fill      = (state == S_FILL);
    cmd.walk_rd   = (state == S_WALK_RD) && !st.walk_done;
    cmd.walk_upd  = (state == S_WALK_UPD);
    cmd.emit_next = (state == S_EMIT) && out_ready;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_FILL;
      end
      S_FILL: begin
        if (st.fill_skip || st.fill_end) state_next = S_WALK_RD;
      end
      S_WALK_RD: begin
        if (st.walk_done) state_next = S_EMIT;
        else state_next = S_WALK_UPD;
      end
      S_WALK_UPD: begin
        state_next = S_WALK_RD;
      end
      S_EMIT: begin
        if (out_ready && st.emit_last) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

[hdl/mcc_datapath.sv]
// datapath: coin registers, count table memory, table fill, walk back and result select
`timescale 1ns / 1ps
`default_nettype none
module mcc_datapath #(
  parameter int MAX_AMOUNT = 1023,
  parameter int NUM_COINS  = 4
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           cfg_we,
  input  wire [mcc_pkg::IDX_W-1:0]      cfg_index,
  input  wire [mcc_pkg::VAL_W-1:0]      cfg_data,
  input  wire [mcc_pkg::VAL_W-1:0]      amount,
  input  mcc_pkg::mcc_cmd_t             cmd,
  output mcc_pkg::mcc_status_t          st,
  output logic [mcc_pkg::VAL_W-1:0]     coin_value,
  output logic [mcc_pkg::CNT_W-1:0]     coin_count,
  output logic                          unreachable,
  output logic                          last
);
  import mcc_pkg::*;

  localparam int DEPTH = MAX_AMOUNT + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(NUM_COINS);
  localparam int SW    = $clog2(NUM_COINS + 1);
  localparam int MW    = CW + BEST_W;

  // denomination registers
  logic [VAL_W-1:0] coin [NUM_COINS];

  // per-request registers
  logic [AW-1:0]     target;
  logic              too_big;
  logic              unreach;
  logic [AW-1:0]     amt;
  logic [SW-1:0]     step;
  logic [BEST_W-1:0] best;
  logic [CW-1:0]     pick;
  logic              rd_skip;
  logic [CW-1:0]     rd_idx;
  logic [AW-1:0]     pos;
  logic [CNT_W-1:0]  counts [NUM_COINS];
  logic [CW-1:0]     emit_idx;

  // count table memory: {chosen coin, best count}
  logic [MW-1:0] tbl_mem [DEPTH];
  logic [MW-1:0] rd_data;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [MW-1:0] wr_data;

  // fill step decode
  logic              fill_go;
  logic              issue;
  logic [CW-1:0]     step_idx;
  logic [VAL_W-1:0]  step_coin;
  logic              skip_now;
  logic [AW-1:0]     fill_addr;
  logic [BEST_W-1:0] rd_best;
  logic [CW-1:0]     rd_choice;
  logic [BEST_W-1:0] cand;
  logic              take;
  logic [BEST_W-1:0] best_eval;
  logic [CW-1:0]     pick_eval;
  logic              final_step;
  logic [VAL_W-1:0]  walk_coin;

  assign fill_go    = cmd.fill && !st.fill_skip;
  assign issue      = (32'(step) < NUM_COINS);
  assign final_step = !issue;
  assign step_idx   = step[CW-1:0];
  assign step_coin  = issue ? coin[step_idx] : '0;
  assign skip_now   = (step_coin == '0) || (32'(step_coin) > 32'(amt));
  assign fill_addr  = amt - AW'(step_coin);

  assign rd_best   = rd_data[BEST_W-1:0];
  assign rd_choice = rd_data[MW-1:BEST_W];

  // candidate from the entry read in the previous step
  assign cand = rd_best + BEST_W'(1);
  assign take = (step != '0) && !rd_skip && !rd_best[UNREACH_BIT] &&
                (best[UNREACH_BIT] || (cand < best));
  assign best_eval = take ? cand : best;
  assign pick_eval = take ? rd_idx : pick;

  // memory address and write selection
  assign rd_addr = cmd.walk_rd ? pos : fill_addr;
  assign wr_en   = cmd.load || (fill_go && final_step);
  assign wr_addr = cmd.load ? '0 : amt;
  assign wr_data = cmd.load ? '0 : {pick_eval, best_eval};

  always_ff @(posedge clk) begin
    if (wr_en) tbl_mem[wr_addr] <= wr_data;
    rd_data <= tbl_mem[rd_addr];
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_COINS; i++) coin[i] <= coin_reset(i);
    end else begin
      for (int i = 0; i < NUM_COINS; i++) begin
        if (cfg_we && (32'(cfg_index) == i)) coin[i] <= cfg_data;
      end
    end
  end

  // table fill: one read per coin, each evaluated from the registered read data, then the entry write
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      target  <= AW'(amount);
      too_big <= (32'(amount) > MAX_AMOUNT);
      unreach <= 1'b0;
      amt     <= AW'(1);
      step    <= '0;
      best    <= BEST_INIT;
      pick    <= '0;
      rd_skip <= 1'b1;
      rd_idx  <= '0;
    end else if (fill_go) begin
      rd_skip <= skip_now;
      rd_idx  <= step_idx;
      if (final_step) begin
        if (amt == target) unreach <= best_eval[UNREACH_BIT];
        amt  <= amt + AW'(1);
        step <= '0;
        best <= BEST_INIT;
        pick <= '0;
      end else begin
        step <= step + SW'(1);
        best <= best_eval;
        pick <= pick_eval;
      end
    end
  end

  // walk back along the chosen coins
  assign walk_coin = coin[rd_choice];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pos <= AW'(amount);
      for (int i = 0; i < NUM_COINS; i++) counts[i] <= '0;
    end else if (cmd.walk_upd) begin
      pos <= pos - AW'(walk_coin);
      for (int i = 0; i < NUM_COINS; i++) begin
        if ((32'(rd_choice) == i) && (counts[i] != CNT_MAX)) counts[i] <= counts[i] + CNT_W'(1);
      end
    end
  end

  // result item select
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      emit_idx <= '0;
    end else if (cmd.emit_next) begin
      emit_idx <= emit_idx + CW'(1);
    end
  end

  assign coin_value  = coin[emit_idx];
  assign unreachable = too_big || unreach;
  assign coin_count  = unreachable ? '0 : counts[emit_idx];
  assign last        = (32'(emit_idx) == NUM_COINS - 1);

  // status
  always_comb begin
    st           = '0;
    st.fill_skip = too_big || (target == '0);
    st.fill_end  = final_step && (amt == target);
    st.walk_done = too_big || unreach || (pos == '0);
    st.emit_last = last;
  end

endmodule
`default_nettype wire

[test/tb_top.sv]
// testbench for the minimum coin change block: directed and random amounts against a table predictor
`timescale 1ns / 1ps
module tb_top;
  import mcc_pkg::*;

  localparam int LIMIT_CYCLES = 6_000_000;
  localparam int HOLD_CYCLES  = 400;
  localparam int TOP_AMOUNT   = 1023;

  typedef enum logic [IDX_W-1:0] {
    COIN_FIRST,
    COIN_SECOND,
    COIN_THIRD,
    COIN_FOURTH
  } coin_reg_t;

  typedef struct {
    logic [VAL_W-1:0] value;
    logic [CNT_W-1:0] count;
    logic             unreach;
    logic             last;
  } change_item_t;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             cfg_we    = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [VAL_W-1:0] cfg_data  = '0;
  logic             in_valid  = 1'b0;
  logic [VAL_W-1:0] amount    = '0;
  logic             out_ready = 1'b0;
  logic             in_ready;
  logic             out_valid;
  logic [VAL_W-1:0] coin_value;
  logic [CNT_W-1:0] coin_count;
  logic             unreachable;
  logic             last;

  // denominations as the block holds them, and the fill tables
  logic [VAL_W-1:0] denom [REG_COUNT];
  int               fewest [0:TOP_AMOUNT];
  int               pick_of [0:TOP_AMOUNT];
  change_item_t     change_q [$];

  int unsigned cycle_count   = 0;
  int          error_count   = 0;
  int          send_idle_pct = 8;
  int          recv_idle_pct = 8;
  logic        out_hold      = 1'b0;
  event        start_hold;

  min_coin_change DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .amount     (amount),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .coin_value (coin_value),
    .coin_count (coin_count),
    .unreachable(unreachable),
    .last       (last)
  );

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    error_count++;
  endtask

  // fewest-coin table for one amount, then walk back and queue the four result items
  function automatic void predict_change(input logic [VAL_W-1:0] amt);
    int best, pick, cand, c, pos, k, guard;
    int used [REG_COUNT];
    logic none, stuck;
    change_item_t r;
    fewest[0]  = 0;
    pick_of[0] = 0;
    for (int a = 1; a <= amt; a++) begin
      best = -1;
      pick = 0;
      for (int i = 0; i < REG_COUNT; i++) begin
        c = int'(denom[i]);
        if (c != 0 && c <= a && fewest[a - c] >= 0) begin
          cand = fewest[a - c] + 1;
          // strict less keeps the earlier denomination on a tie
          if (best < 0 || cand < best) begin
            best = cand;
            pick = i;
          end
        end
      end
      fewest[a]  = best;
      pick_of[a] = pick;
    end
    for (int i = 0; i < REG_COUNT; i++) used[i] = 0;
    none = (fewest[amt] < 0);
    if (!none) begin
      pos   = int'(amt);
      guard = 0;
      stuck = 1'b0;
      while (pos > 0 && guard <= amt && !stuck) begin
        k = pick_of[pos];
        c = int'(denom[k]);
        if (c == 0 || c > pos) begin
          stuck = 1'b1;
        end else begin
          if (used[k] < CNT_MAX) used[k]++;
          pos -= c;
          guard++;
        end
      end
    end
    for (int i = 0; i < REG_COUNT; i++) begin
      r.value   = denom[i];
      r.count   = none ? '0 : CNT_W'(used[i]);
      r.unreach = none;
      r.last    = (i == REG_COUNT - 1);
      change_q  = {change_q, r};
    end
  endfunction

  // result checker
  always @(posedge clk) begin : check_results
    change_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (change_q.size() == 0) begin
        report_mismatch("unexpected result, coin_value", int'(coin_value), 0);
      end else begin
        want = change_q.pop_front();
        if (coin_value !== want.value)
          report_mismatch("coin_value", int'(coin_value), int'(want.value));
        if (coin_count !== want.count)
          report_mismatch("coin_count", int'(coin_count), int'(want.count));
        if (unreachable !== want.unreach)
          report_mismatch("unreachable", int'(unreachable), int'(want.unreach));
        if (last !== want.last) report_mismatch("last", int'(last), int'(want.last));
      end
    end
  end

  // receiver ready, with random stalls
  always @(negedge clk) begin
    if (out_hold) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // long receiver hold-off, counted in cycles
  always begin
    @(start_hold);
    @(posedge clk);
    out_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    out_hold <= 1'b0;
  end

  // offer one amount and wait until it is accepted
  task automatic send_amount(input logic [VAL_W-1:0] amt);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    amount   = amt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_change(amt);
    @(negedge clk);
  endtask

  // wait until every queued result has come back and the block is quiet
  task automatic drain_results();
    in_valid = 1'b0;
    while (change_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_coin(input coin_reg_t idx, input int val);
    cfg_we     = 1'b1;
    cfg_index  = idx;
    cfg_data   = VAL_W'(val);
    denom[idx] = VAL_W'(val);
    @(negedge clk);
  endtask

  task automatic load_coins(input int c0, input int c1, input int c2, input int c3);
    drain_results();
    write_coin(COIN_FIRST, c0);
    write_coin(COIN_SECOND, c1);
    write_coin(COIN_THIRD, c2);
    write_coin(COIN_FOURTH, c3);
    cfg_we = 1'b0;
  endtask

  // mostly small denominations, now and then a large one or an unused zero
  function automatic int rand_coin();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 0;
    if (r < 20) return $urandom_range(1, 1023);
    return $urandom_range(1, 40);
  endfunction

  task automatic load_random_coins();
    load_coins(rand_coin(), rand_coin(), rand_coin(), rand_coin());
  endtask

  // amounts kept mostly small, since fill time grows with the amount
  task automatic send_random_amounts(input int n);
    int r;
    logic [VAL_W-1:0] amt;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 75) amt = VAL_W'($urandom_range(0, 63));
      else if (r < 95) amt = VAL_W'($urandom_range(0, 255));
      else amt = VAL_W'($urandom_range(0, 1023));
      send_amount(amt);
    end
  endtask

  // reset denominations: zero, coin edges, greedy trap and the largest amount
  task automatic test_reset_coins();
    int amts [10] = '{0, 1, 4, 5, 29, 30, 49, 60, 99, 1023};
    foreach (amts[i]) send_amount(VAL_W'(amts[i]));
  endtask

  // amounts that no combination reaches, mixed with reachable ones
  task automatic test_unreachable();
    load_coins(7, 11, 13, 17);
    send_amount(1);
    send_amount(6);
    send_amount(0);
    send_amount(24);
    send_amount(1023);
    load_coins(1023, 1023, 1023, 1023);
    send_amount(1022);
    send_amount(1023);
  endtask

  // denominations set to zero are never used
  task automatic test_zero_coin();
    load_coins(0, 3, 0, 2);
    send_amount(1);
    send_amount(7);
    send_amount(6);
    load_coins(0, 0, 0, 0);
    send_amount(0);
    send_amount(5);
  endtask

  // equal counts go to the earlier denomination, largest count reachable
  task automatic test_tie_break();
    load_coins(4, 4, 1, 2);
    send_amount(8);
    send_amount(3);
    load_coins(1, 1, 1, 1);
    send_amount(1023);
  endtask

  task automatic test_random_amounts();
    load_random_coins();
    send_random_amounts(25);
    load_random_coins();
    send_random_amounts(25);
  endtask

  // stretch with no idling on either side
  task automatic test_no_idle();
    load_random_coins();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random_amounts(35);
    drain_results();
    send_idle_pct = 8;
    recv_idle_pct = 8;
  endtask

  // receiver holds off while amounts keep coming, so the input stalls
  task automatic test_back_pressure();
    load_random_coins();
    -> start_hold;
    send_random_amounts(35);
  endtask

  initial begin
    for (int i = 0; i < REG_COUNT; i++) denom[i] = coin_reset(i);
    repeat (12) @(negedge clk);
    rst = 1'b0;
    test_reset_coins();
    test_unreachable();
    test_zero_coin();
    test_tie_break();
    test_random_amounts();
    test_no_idle();
    test_back_pressure();
    drain_results();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
